/* rtl/core/ufd_pkg.sv */
`timescale 1ns / 1ps

package ufd_pkg;

    // frame delimiter and checksum seed, and max payload length reset value
    localparam logic [7:0]  START_BYTE      = 8'hFE;
    localparam logic [15:0] MAX_LEN_RESET   = 16'd128;

    // register map
    localparam logic        REG_MAX_LEN     = 1'b0;

    // receive phases
    typedef enum logic [2:0] {
        PH_WAIT    = 3'd0,
        PH_FUNC_HI = 3'd1,
        PH_FUNC_LO = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_LEN_LO  = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CHECK   = 3'd6
    } t_phase;

    // result kinds
    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2,
        KIND_TOOLONG = 2'd3
    } t_kind;

    // one result item
    typedef struct packed {
        t_kind       kind;
        logic [15:0] function_code;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
    } t_result;

    // result handoff from the frame logic to the output buffer
    typedef struct packed {
        logic    valid;
        t_result res;
    } t_result_req;

endpackage

/* rtl/core/ufd_if.sv */
`timescale 1ns / 1ps

// received byte channel
interface ufd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// decoded result channel
interface ufd_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] function_code;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;

    modport source (output valid, output kind, output function_code,
                    output payload_length, output data_byte, output byte_index,
                    input ready);
    modport sink   (input valid, input kind, input function_code,
                    input payload_length, input data_byte, input byte_index,
                    output ready);
endinterface

/* rtl/core/uart_frame_decoder.sv */
`timescale 1ns / 1ps
// a result is registered in the output buffer when its byte is accepted, or in
// its skid slot if the output waits; one byte per cycle while the skid is free
// a two-entry output buffer keeps bytes flowing while one result waits
// reset (i_rst_n low, synchronous): hunt for start byte, fields cleared,
// checksum seed restored, max payload length back to 128, outputs empty

module uart_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ufd_rx_if.sink      i_rx,
    ufd_res_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                  w_max_len_unused_hi;
    logic [15:0]           w_max_len;
    logic                  w_in_ready;
    logic                  w_accept;
    ufd_pkg::t_result_req  w_req;
    ufd_pkg::t_result      w_res;

    assign w_max_len_unused_hi = 1'b0;
    assign i_rx.ready = w_in_ready | w_max_len_unused_hi;
    assign w_accept   = i_rx.valid && i_rx.ready;

    // configuration registers
    ufd_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_max_len (w_max_len)
    );

    // frame parser
    ufd_frame_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_rx_byte (i_rx.rx_byte),
        .i_max_len (w_max_len),
        .o_req     (w_req)
    );

    // result buffer
    ufd_out_buf u_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .o_in_ready (w_in_ready),
        .o_valid    (o_res.valid),
        .i_ready    (o_res.ready),
        .o_res      (w_res)
    );

    assign o_res.kind           = w_res.kind;
    assign o_res.function_code  = w_res.function_code;
    assign o_res.payload_length = w_res.payload_length;
    assign o_res.data_byte      = w_res.data_byte;
    assign o_res.byte_index     = w_res.byte_index;

endmodule

/* rtl/core/ufd_cfg_regs.sv */
`timescale 1ns / 1ps

module ufd_cfg_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] o_max_len
);

    logic [15:0] r_max_len;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr[2] == ufd_pkg::REG_MAX_LEN);

    // max payload length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= ufd_pkg::MAX_LEN_RESET;
        end else if (w_wr) begin
            r_max_len <= pwdata[15:0];
        end
    end

    // read back
    always_comb begin
        if (paddr[2] == ufd_pkg::REG_MAX_LEN) begin
            prdata = {16'd0, r_max_len};
        end else begin
            prdata = 32'd0;
        end
    end

    assign o_max_len = r_max_len;

endmodule

/* rtl/core/ufd_frame_fsm.sv */
`timescale 1ns / 1ps

module ufd_frame_fsm (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_rx_byte,
    input  logic [15:0]           i_max_len,
    output ufd_pkg::t_result_req  o_req
);

    ufd_pkg::t_phase r_phase, n_phase;
    logic [15:0]     r_func,  n_func;
    logic [15:0]     r_len,   n_len;
    logic [15:0]     r_index, n_index;
    logic [7:0]      r_xor,   n_xor;

    logic [15:0]     w_len_full;
    logic [15:0]     w_index_inc;

    assign w_len_full  = {r_len[15:8], i_rx_byte};
    assign w_index_inc = r_index + 16'd1;

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            ufd_pkg::PH_WAIT: begin
                if (i_rx_byte == ufd_pkg::START_BYTE) begin
                    n_phase = ufd_pkg::PH_FUNC_HI;
                end
            end
            ufd_pkg::PH_FUNC_HI: n_phase = ufd_pkg::PH_FUNC_LO;
            ufd_pkg::PH_FUNC_LO: n_phase = ufd_pkg::PH_LEN_HI;
            ufd_pkg::PH_LEN_HI:  n_phase = ufd_pkg::PH_LEN_LO;
            ufd_pkg::PH_LEN_LO: begin
                if (w_len_full > i_max_len) begin
                    n_phase = ufd_pkg::PH_WAIT;
                end else if (w_len_full != 16'd0) begin
                    n_phase = ufd_pkg::PH_PAYLOAD;
                end else begin
                    n_phase = ufd_pkg::PH_CHECK;
                end
            end
            ufd_pkg::PH_PAYLOAD: begin
                if (w_index_inc >= r_len) begin
                    n_phase = ufd_pkg::PH_CHECK;
                end
            end
            ufd_pkg::PH_CHECK: n_phase = ufd_pkg::PH_WAIT;
            default:           n_phase = ufd_pkg::PH_WAIT;
        endcase
    end

    // field updates and result
    always_comb begin
        n_func  = r_func;
        n_len   = r_len;
        n_index = r_index;
        n_xor   = r_xor;
        o_req.valid              = 1'b0;
        o_req.res.kind           = ufd_pkg::KIND_DATA;
        o_req.res.function_code  = r_func;
        o_req.res.payload_length = r_len;
        o_req.res.data_byte      = 8'd0;
        o_req.res.byte_index     = 16'd0;
        case (r_phase)
            ufd_pkg::PH_WAIT: begin
                n_func  = 16'd0;
                n_len   = 16'd0;
                n_index = 16'd0;
                n_xor   = ufd_pkg::START_BYTE;
            end
            ufd_pkg::PH_FUNC_HI: begin
                n_func = {i_rx_byte, 8'd0};
                n_xor  = r_xor ^ i_rx_byte;
            end
            ufd_pkg::PH_FUNC_LO: begin
                n_func = {r_func[15:8], i_rx_byte};
                n_xor  = r_xor ^ i_rx_byte;
            end
            ufd_pkg::PH_LEN_HI: begin
                n_len = {i_rx_byte, 8'd0};
                n_xor = r_xor ^ i_rx_byte;
            end
            ufd_pkg::PH_LEN_LO: begin
                n_len   = w_len_full;
                n_xor   = r_xor ^ i_rx_byte;
                n_index = 16'd0;
                // frame too long: abandon with an error result
                if (w_len_full > i_max_len) begin
                    o_req.valid              = i_accept;
                    o_req.res.kind           = ufd_pkg::KIND_TOOLONG;
                    o_req.res.payload_length = w_len_full;
                end
            end
            ufd_pkg::PH_PAYLOAD: begin
                o_req.valid          = i_accept;
                o_req.res.kind       = ufd_pkg::KIND_DATA;
                o_req.res.data_byte  = i_rx_byte;
                o_req.res.byte_index = r_index;
                n_xor   = r_xor ^ i_rx_byte;
                n_index = w_index_inc;
            end
            ufd_pkg::PH_CHECK: begin
                o_req.valid    = i_accept;
                o_req.res.kind = (r_xor == i_rx_byte) ? ufd_pkg::KIND_GOOD
                                                      : ufd_pkg::KIND_BAD;
            end
            default: begin
                n_func = r_func;
            end
        endcase
    end

    // frame state, advanced once per accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ufd_pkg::PH_WAIT;
            r_func  <= 16'd0;
            r_len   <= 16'd0;
            r_index <= 16'd0;
            r_xor   <= ufd_pkg::START_BYTE;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_func  <= n_func;
            r_len   <= n_len;
            r_index <= n_index;
            r_xor   <= n_xor;
        end
    end

endmodule

/* rtl/core/ufd_out_buf.sv */
`timescale 1ns / 1ps

module ufd_out_buf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ufd_pkg::t_result_req  i_req,
    output logic                  o_in_ready,
    output logic                  o_valid,
    input  logic                  i_ready,
    output ufd_pkg::t_result      o_res
);

    logic              r_out_valid;
    ufd_pkg::t_result  r_out;
    logic              r_skid_valid;
    ufd_pkg::t_result  r_skid;

    // a free skid slot lets the next byte in while a result waits
    assign o_in_ready = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_res      = r_out;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_req.valid;
            end
        end else if (i_req.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else begin
                r_out <= i_req.res;
            end
        end else if (i_req.valid) begin
            r_skid <= i_req.res;
        end
    end

endmodule
